/* rtl/tilt_compass_complementary_filter_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tilt compass filter
// Implication and next-cycle checks, removed when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TILT_COMPASS_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`define TILT_COMPASS_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define TCCF_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tccf check failed");
`define TCCF_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tccf check failed");
`else
`define TCCF_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define TCCF_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

/* rtl/tccf_pkg.sv */
// ----------------------------------------------------------------------------
// tccf_pkg
// Widths, constants, CORDIC angle table and shared types of the tilt compass.
// ----------------------------------------------------------------------------
package tccf_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int IDX_W        = 5;
	localparam int ANG_W        = 26;
	localparam int VEC_W        = 54;
	localparam int ROT_W        = 34;
	localparam int SC_W         = 32;
	localparam int EST_W        = 28;
	localparam int ACC_W        = 25;
	localparam int OFF_W        = 27;
	localparam int WRAP_W       = 29;

	localparam logic signed [ANG_W-1:0]  ANG_QTR      = 26'sd5898240;
	localparam logic signed [WRAP_W-1:0] FULL_TURN    = 29'sd23592960;
	localparam logic signed [WRAP_W-1:0] HALF_TURN    = 29'sd11796480;
	localparam logic signed [WRAP_W-1:0] QTR_TURN     = 29'sd5898240;
	localparam logic signed [ROT_W-1:0]  CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [EST_W-1:0]  EST_MIN      = -28'sd67108864;
	localparam logic signed [EST_W-1:0]  EST_MAX      = 28'sd67109887;
	localparam logic [24:0]              GYRO_SCALE   = 25'd24608350;
	localparam logic signed [OFF_W-1:0]  OFF_NONE     = 27'sd0;
	localparam logic signed [OFF_W-1:0]  OFF_NEG_HALF = -27'sd11796480;
	localparam logic signed [OFF_W-1:0]  OFF_POS_HALF = 27'sd11796480;
	localparam logic signed [OFF_W-1:0]  OFF_NEG_FULL = -27'sd23592960;
	localparam logic                     REG_GYRO_WEIGHT = 1'b0;
	localparam logic [15:0]              WEIGHT_RESET = 16'd62259;

	typedef enum logic [2:0] {
		T_IDLE, T_START, T_LANES, T_MERGE, T_HOLD
	} top_state_t;

	typedef enum logic [3:0] {
		L_IDLE, L_ATAN, L_TMUL, L_SMUL, L_SUM, L_WMUL, L_AMUL, L_BLEND,
		L_WRAP, L_ROT, L_DONE
	} lane_state_t;

	typedef enum logic [2:0] {
		M_IDLE, M_PROD1, M_PROD2, M_SUM, M_VSTART, M_VEC
	} merge_state_t;

	typedef struct packed {
		logic                    done;
		logic signed [SC_W-1:0]  sin_v;
		logic signed [SC_W-1:0]  cos_v;
		logic signed [EST_W-1:0] est;
	} lane_res_t;

	// atan(2^-i) in degrees, Q.16, rounded to nearest
	function automatic logic signed [ANG_W-1:0] atan_tab(input logic [IDX_W-1:0] i);
		logic signed [ANG_W-1:0] v;
		case (i)
			5'd0:    v = 26'sd2949120;
			5'd1:    v = 26'sd1740967;
			5'd2:    v = 26'sd919879;
			5'd3:    v = 26'sd466945;
			5'd4:    v = 26'sd234379;
			5'd5:    v = 26'sd117304;
			5'd6:    v = 26'sd58666;
			5'd7:    v = 26'sd29335;
			5'd8:    v = 26'sd14668;
			5'd9:    v = 26'sd7334;
			5'd10:   v = 26'sd3667;
			5'd11:   v = 26'sd1833;
			5'd12:   v = 26'sd917;
			5'd13:   v = 26'sd458;
			5'd14:   v = 26'sd229;
			5'd15:   v = 26'sd115;
			5'd16:   v = 26'sd57;
			5'd17:   v = 26'sd29;
			5'd18:   v = 26'sd14;
			5'd19:   v = 26'sd7;
			5'd20:   v = 26'sd4;
			5'd21:   v = 26'sd2;
			5'd22:   v = 26'sd1;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/tccf_vec_cordic.sv */
// ----------------------------------------------------------------------------
// tccf_vec_cordic
// Iterative vectoring CORDIC: atan(y/x) in degrees Q.16 for x, y >= 0.
// ----------------------------------------------------------------------------
module tccf_vec_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tccf_pkg::VEC_W-1:0]   x_in,
	input  logic signed [tccf_pkg::VEC_W-1:0]   y_in,
	output logic                                done,
	output logic signed [tccf_pkg::ANG_W-1:0]   angle
);
	import tccf_pkg::*;

	logic signed [VEC_W-1:0] x_q, y_q, xs, ys;
	logic signed [ANG_W-1:0] z_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    busy_q, done_q;

	assign xs = x_q >>> idx_q;
	assign ys = y_q >>> idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (busy_q) begin
			// A zero residue means the angle is exact; stop there.
			if (y_q == '0 || idx_q == IDX_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x_in;
			y_q <= y_in;
			z_q <= '0;
		end else if (busy_q && y_q != '0) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_tab(idx_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_tab(idx_q);
			end
		end
	end

	assign done  = done_q;
	assign angle = (z_q < 0) ? '0 : ((z_q > ANG_QTR) ? ANG_QTR : z_q);

endmodule

/* rtl/tccf_rot_cordic.sv */
// ----------------------------------------------------------------------------
// tccf_rot_cordic
// Iterative rotation CORDIC: sine and cosine (Q30) of an angle within 90 deg.
// ----------------------------------------------------------------------------
module tccf_rot_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tccf_pkg::ANG_W-1:0]   a_in,
	output logic                                done,
	output logic signed [tccf_pkg::ROT_W-1:0]   x_out,
	output logic signed [tccf_pkg::ROT_W-1:0]   y_out
);
	import tccf_pkg::*;

	logic signed [ROT_W-1:0] x_q, y_q, xs, ys;
	logic signed [ANG_W-1:0] z_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    busy_q, done_q;

	assign xs = x_q >>> idx_q;
	assign ys = y_q >>> idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (idx_q == IDX_W'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= a_in;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_tab(idx_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_tab(idx_q);
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;

endmodule

/* rtl/tccf_lane.sv */
// ----------------------------------------------------------------------------
// tccf_lane
// One attitude axis: accelerometer angle, gyro increment, weighted blend,
// saturation, and sine and cosine of the new estimate.
// ----------------------------------------------------------------------------
module tccf_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [16:0]   num,
	input  logic signed [15:0]   az,
	input  logic signed [15:0]   rate,
	input  logic [15:0]          ms,
	input  logic [15:0]          weight,
	output tccf_pkg::lane_res_t  res
);
	import tccf_pkg::*;

	lane_state_t state_q, state_d;

	logic                    vec_done, rot_done, rot_start;
	logic signed [ANG_W-1:0] vec_angle;
	logic signed [ROT_W-1:0] rot_x, rot_y;
	logic signed [VEC_W-1:0] vec_x, vec_y;
	logic [16:0]             num_abs, az_abs;
	logic signed [16:0]      az_x, rate_x;
	logic                    n_ge, n_le, a_ge, a_le;
	logic signed [OFF_W-1:0] off_sel, acc_sum;
	logic [ACC_W-1:0]        acc_abs, acc_q;

	logic [16:0]             rate_mag;
	logic [19:0]             ten_prod;
	logic [8:0]              ten_mag;
	logic signed [9:0]       ten;
	logic signed [26:0]      tm_q;
	logic signed [52:0]      sc_q;
	logic [52:0]             sc_mag;
	logic [36:0]             sc_rnd;
	logic signed [37:0]      inc;
	logic signed [38:0]      ei_q;
	logic signed [55:0]      pw_q;
	logic [16:0]             w_comp;
	logic [41:0]             pa_q;
	logic signed [56:0]      bl_sum;
	logic [56:0]             bl_mag;
	logic [40:0]             bl_rnd;
	logic signed [41:0]      bl_val;
	logic signed [EST_W-1:0] est_new, est_q;

	logic signed [WRAP_W-1:0] wa_q, a1, a2;
	logic                     wrap_ok, flip_c, flip_q;
	logic signed [ROT_W-1:0]  sin_f, cos_f;
	logic signed [SC_W-1:0]   sin_q, cos_q;

	// Accelerometer angle
	assign az_x    = 17'(az);
	assign az_abs  = az_x[16] ? 17'(-az_x) : 17'(az_x);
	assign num_abs = num[16] ? 17'(-num) : 17'(num);
	assign vec_x   = $signed(VEC_W'({az_abs, 16'h0000}));
	assign vec_y   = $signed(VEC_W'({num_abs, 16'h0000}));

	tccf_vec_cordic u_vec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.x_in   (vec_x),
		.y_in   (vec_y),
		.done   (vec_done),
		.angle  (vec_angle)
	);

	// Quadrant offset, first match wins.
	assign n_ge = !num[16];
	assign n_le = num[16] || (num == '0);
	assign a_ge = !az[15];
	assign a_le = az[15] || (az == '0);

	always_comb begin
		if (n_ge && a_ge) begin
			off_sel = OFF_NONE;
		end else if (n_ge && a_le) begin
			off_sel = OFF_NEG_HALF;
		end else if (n_le && a_le) begin
			off_sel = OFF_POS_HALF;
		end else begin
			off_sel = OFF_NEG_FULL;
		end
	end

	assign acc_sum = off_sel + OFF_W'(vec_angle);
	assign acc_abs = acc_sum[OFF_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);

	// Gyro rate rounded to tenths, half away from zero
	assign rate_x   = 17'(rate);
	assign rate_mag = rate_x[16] ? 17'(-rate_x) : 17'(rate_x);
	assign ten_prod = 20'(rate_mag) * 20'd10 + 20'd1024;
	assign ten_mag  = ten_prod[19:11];
	assign ten      = rate[15] ? -$signed({1'b0, ten_mag}) : $signed({1'b0, ten_mag});

	assign sc_mag = sc_q[52] ? 53'(-sc_q) : 53'(sc_q);
	assign sc_rnd = 37'((sc_mag + 53'd32768) >> 16);
	assign inc    = sc_q[52] ? -$signed({1'b0, sc_rnd}) : $signed({1'b0, sc_rnd});

	assign w_comp = 17'h10000 - {1'b0, weight};

	// Blend, rounded half away from zero, then saturated
	assign bl_sum = 57'(pw_q) + $signed(57'(pa_q));
	assign bl_mag = bl_sum[56] ? 57'(-bl_sum) : 57'(bl_sum);
	assign bl_rnd = 41'((bl_mag + 57'd32768) >> 16);
	assign bl_val = bl_sum[56] ? -$signed({1'b0, bl_rnd}) : $signed({1'b0, bl_rnd});

	always_comb begin
		if (bl_val < EST_MIN) begin
			est_new = EST_MIN;
		end else if (bl_val > EST_MAX) begin
			est_new = EST_MAX;
		end else begin
			est_new = EST_W'(bl_val);
		end
	end

	// Angle folding into [-90, 90] with a sign flip of sine and cosine
	assign wrap_ok = !wa_q[WRAP_W-1] && (wa_q < FULL_TURN);
	assign a1      = (wa_q >= HALF_TURN) ? wa_q - FULL_TURN : wa_q;

	always_comb begin
		if (a1 > QTR_TURN) begin
			a2     = a1 - HALF_TURN;
			flip_c = 1'b1;
		end else if (a1 < -QTR_TURN) begin
			a2     = a1 + HALF_TURN;
			flip_c = 1'b1;
		end else begin
			a2     = a1;
			flip_c = 1'b0;
		end
	end

	tccf_rot_cordic u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rot_start),
		.a_in   (ANG_W'(a2)),
		.done   (rot_done),
		.x_out  (rot_x),
		.y_out  (rot_y)
	);

	assign sin_f = flip_q ? -rot_y : rot_y;
	assign cos_f = flip_q ? -rot_x : rot_x;

	always_comb begin
		state_d = state_q;
		case (state_q)
			L_IDLE, L_DONE: begin
				if (start) state_d = L_ATAN;
			end
			L_ATAN: begin
				if (vec_done) state_d = L_TMUL;
			end
			L_TMUL:  state_d = L_SMUL;
			L_SMUL:  state_d = L_SUM;
			L_SUM:   state_d = L_WMUL;
			L_WMUL:  state_d = L_AMUL;
			L_AMUL:  state_d = L_BLEND;
			L_BLEND: state_d = L_WRAP;
			L_WRAP: begin
				if (wrap_ok) state_d = L_ROT;
			end
			L_ROT: begin
				if (rot_done) state_d = L_DONE;
			end
			default: state_d = L_IDLE;
		endcase
	end

	always_comb begin
		rot_start = (state_q == L_WRAP) && wrap_ok;
		res.done  = (state_q == L_DONE);
		res.sin_v = sin_q;
		res.cos_v = cos_q;
		res.est   = est_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			est_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == L_BLEND) est_q <= est_new;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_ATAN: begin
				if (vec_done) acc_q <= acc_abs;
			end
			L_TMUL:  tm_q <= ten * $signed({1'b0, ms});
			L_SMUL:  sc_q <= tm_q * $signed({1'b0, GYRO_SCALE});
			L_SUM:   ei_q <= 39'(est_q) + 39'(inc);
			L_WMUL:  pw_q <= ei_q * $signed({1'b0, weight});
			L_AMUL:  pa_q <= 42'(acc_q) * 42'(w_comp);
			L_BLEND: wa_q <= WRAP_W'(est_new);
			L_WRAP: begin
				// Bring the angle into one turn, one turn per cycle.
				if (!wrap_ok) begin
					if (wa_q[WRAP_W-1]) begin
						wa_q <= wa_q + FULL_TURN;
					end else begin
						wa_q <= wa_q - FULL_TURN;
					end
				end else begin
					flip_q <= flip_c;
				end
			end
			L_ROT: begin
				if (rot_done) begin
					sin_q <= SC_W'(sin_f);
					cos_q <= SC_W'(cos_f);
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/tccf_merge.sv */
// ----------------------------------------------------------------------------
// tccf_merge
// Combines both lanes: projects the magnetic field with pitch and roll and
// takes the heading with a vectoring CORDIC.
// ----------------------------------------------------------------------------
module tccf_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  tccf_pkg::lane_res_t  pitch,
	input  tccf_pkg::lane_res_t  roll,
	input  logic signed [15:0]   mx,
	input  logic signed [15:0]   my,
	input  logic signed [15:0]   mz,
	output logic                 done,
	output logic signed [15:0]   heading
);
	import tccf_pkg::*;

	merge_state_t state_q, state_d;

	logic signed [2*SC_W-1:0] spst_full, cpst_full;
	logic signed [33:0]       spst_q, cpst_q;
	logic signed [49:0]       t1_q, t2_q, t3_q, t4_q, t5_q;
	logic signed [51:0]       px_q, py_q, px_abs, py_abs;
	logic                     vec_start, vec_done, done_q;
	logic signed [ANG_W-1:0]  vec_angle, h_sum;
	logic [17:0]              h_mag;
	logic signed [15:0]       heading_q;

	assign spst_full = roll.sin_v * pitch.sin_v;
	assign cpst_full = roll.cos_v * pitch.sin_v;

	assign px_abs = px_q[51] ? -px_q : px_q;
	assign py_abs = py_q[51] ? -py_q : py_q;

	tccf_vec_cordic u_vec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vec_start),
		.x_in   (VEC_W'(px_abs)),
		.y_in   (VEC_W'(py_abs)),
		.done   (vec_done),
		.angle  (vec_angle)
	);

	// Round half up to Q.8; the sign goes on afterwards.
	assign h_sum = vec_angle + 26'sd128;
	assign h_mag = h_sum[25:8];

	always_comb begin
		state_d = state_q;
		case (state_q)
			M_IDLE: begin
				if (start) state_d = M_PROD1;
			end
			M_PROD1:  state_d = M_PROD2;
			M_PROD2:  state_d = M_SUM;
			M_SUM:    state_d = M_VSTART;
			M_VSTART: state_d = M_VEC;
			M_VEC: begin
				if (vec_done) state_d = M_IDLE;
			end
			default:  state_d = M_IDLE;
		endcase
	end

	always_comb begin
		vec_start = (state_q == M_VSTART);
		done      = done_q;
		heading   = heading_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == M_VEC) && vec_done;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_PROD1: begin
				spst_q <= $signed(spst_full[63:30]);
				cpst_q <= $signed(cpst_full[63:30]);
			end
			M_PROD2: begin
				t1_q <= mx * pitch.cos_v;
				t2_q <= my * spst_q;
				t3_q <= mz * cpst_q;
				t4_q <= my * roll.cos_v;
				t5_q <= mz * roll.sin_v;
			end
			M_SUM: begin
				px_q <= 52'(t1_q) + 52'(t2_q) - 52'(t3_q);
				py_q <= 52'(t4_q) + 52'(t5_q);
			end
			M_VEC: begin
				if (vec_done) begin
					if (py_q[51] != px_q[51]) begin
						heading_q <= -$signed(16'(h_mag));
					end else begin
						heading_q <= $signed(16'(h_mag));
					end
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/tilt_compass_complementary_filter_top.sv */
// ----------------------------------------------------------------------------
// tilt_compass_complementary_filter_top
// Complementary pitch/roll filter with a tilt-compensated compass heading.
//
// Usage: one IMU sample per input transfer on the s_axis channel, one result
// per sample on the m_axis channel. The blend weight of the gyro path sits in
// an APB register at address 0; the user must write it only while the block
// is idle; the block itself does not enforce this. The pitch and roll lanes
// run side by side, each with a 16-step vectoring and a 16-step rotation
// CORDIC, and fold an estimate outside one turn back by whole turns before
// the rotation CORDIC; the merge stage then runs one more 16-step vectoring
// CORDIC for the heading. A vectoring CORDIC stops early once its residue is
// zero. One sample is in work at a time: s_axis_tready is high only between
// samples, so a new one is taken only after the last reaches the result
// register, which frees the core: the next sample is taken while a result
// still waits. If the receiver stalls, a further finished result waits inside
// until the register is free. Reset clears both estimates, restores the
// default weight and empties the result register.
// ----------------------------------------------------------------------------
`include "tilt_compass_complementary_filter_top_macros.svh"

module tilt_compass_complementary_filter_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, field_x, field_y, field_z,
	// elapsed_ms, 16 bits each, from bit 0 up
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pitch_deg [16:0], roll_deg [33:17], heading_deg [49:34], zeros above
	output logic [55:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import tccf_pkg::*;

	top_state_t state_q, state_d;

	logic [143:0]       in_q;
	logic [15:0]        weight_q;
	logic               lane_start, mrg_start, mrg_done, out_free, out_load, accept;
	lane_res_t          pitch_res, roll_res;
	logic signed [15:0] heading;
	logic               out_valid_q;
	logic [16:0]        pitch_q, roll_q;
	logic [15:0]        heading_q;

	assign accept = s_axis_tvalid && s_axis_tready;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GYRO_WEIGHT) ? {16'h0000, weight_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_GYRO_WEIGHT) begin
			weight_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) in_q <= s_axis_tdata;
	end

	tccf_lane u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.num    (17'($signed(in_q[15:0]))),
		.az     ($signed(in_q[47:32])),
		.rate   ($signed(in_q[79:64])),
		.ms     (in_q[143:128]),
		.weight (weight_q),
		.res    (pitch_res)
	);

	// The roll lane sees -accel_y, which turns its quadrant rule into the pitch rule.
	tccf_lane u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.num    (-17'($signed(in_q[31:16]))),
		.az     ($signed(in_q[47:32])),
		.rate   ($signed(in_q[63:48])),
		.ms     (in_q[143:128]),
		.weight (weight_q),
		.res    (roll_res)
	);

	tccf_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mrg_start),
		.pitch   (pitch_res),
		.roll    (roll_res),
		.mx      ($signed(in_q[95:80])),
		.my      ($signed(in_q[111:96])),
		.mz      ($signed(in_q[127:112])),
		.done    (mrg_done),
		.heading (heading)
	);

	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE: begin
				if (accept) state_d = T_START;
			end
			T_START: state_d = T_LANES;
			T_LANES: begin
				if (pitch_res.done && roll_res.done) state_d = T_MERGE;
			end
			T_MERGE: begin
				if (mrg_done) state_d = out_free ? T_IDLE : T_HOLD;
			end
			T_HOLD: begin
				if (out_free) state_d = T_IDLE;
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == T_IDLE);
		lane_start    = (state_q == T_START);
		mrg_start     = (state_q == T_LANES) && pitch_res.done && roll_res.done;
		out_load      = ((state_q == T_MERGE && mrg_done) || state_q == T_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pitch_q   <= pitch_res.est[26:10];
			roll_q    <= roll_res.est[26:10];
			heading_q <= heading;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b000000, heading_q, roll_q, pitch_q};

	`TCCF_ASSERT_NXT(a_accept_starts, clk, arst_n, accept, state_q == T_START)
	`TCCF_ASSERT_IMP(a_merge_done_state, clk, arst_n, mrg_done, state_q == T_MERGE)
	`TCCF_ASSERT_IMP(a_out_load_src, clk, arst_n, $rose(m_axis_tvalid), $past(state_q) == T_MERGE || $past(state_q) == T_HOLD)

endmodule
